@@ rtl/core/glyph_pixel_renderer_3x5_top_macros.svh @@
// assertion helpers for the glyph renderer
`ifndef GLYPH_PIXEL_RENDERER_3X5_TOP_MACROS_SVH
`define GLYPH_PIXEL_RENDERER_3X5_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gpr_pkg.sv @@
package gpr_pkg;

  // font geometry
  localparam int GLYPH_BITS    = 15;
  localparam int FONT_ROM_BITS = 152;
  localparam int GLYPH_IDX_W   = 6;

  // packed font, ten digits back to back, first pixel in the top bit
  localparam logic [FONT_ROM_BITS-1:0] FONT_ROM =
    152'hF6DF925F9F3F3CF9375E73F4F7F249F7DFEF24;

  // register indexes
  localparam logic REG_SET_COLOUR   = 1'b0;
  localparam logic REG_CLEAR_COLOUR = 1'b1;

  // scale codes and window extents
  localparam logic [1:0] SCALE_TWO    = 2'd2;
  localparam logic [7:0] X_SPAN_ONE   = 8'd2;
  localparam logic [7:0] X_SPAN_TWO   = 8'd5;
  localparam logic [7:0] Y_SPAN_ONE   = 8'd4;
  localparam logic [7:0] Y_SPAN_TWO   = 8'd9;

  // sequencer limits
  localparam logic [2:0] LAST_ROW = 3'd4;
  localparam logic [1:0] LAST_COL = 2'd2;
  localparam logic [3:0] LAST_BIT = 4'd14;

  // one glyph request as held between front and back
  typedef struct packed {
    logic [GLYPH_BITS-1:0] bits;
    logic [7:0]            x_first;
    logic [7:0]            x_last;
    logic [7:0]            y_first;
    logic [7:0]            y_last;
    logic                  scale2;
  } desc_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic active;
    logic final_step;
  } back_status_t;

  // fetch 15 glyph bits, bits past the rom read as zero
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GLYPH_IDX_W-1:0] g);
    logic [GLYPH_BITS-1:0] bits;
    int base;
    int idx;
    base = int'(g) * GLYPH_BITS;
    for (int i = 0; i < GLYPH_BITS; i++) begin
      idx = base + i;
      if (idx < FONT_ROM_BITS) begin
        bits[GLYPH_BITS-1-i] = FONT_ROM[FONT_ROM_BITS-1-idx];
      end else begin
        bits[GLYPH_BITS-1-i] = 1'b0;
      end
    end
    return bits;
  endfunction

endpackage

@@ rtl/core/gpr_front.sv @@
module gpr_front #(
  parameter int GLYPH_COUNT = 10
) (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_glyph_code,
  input  logic [7:0]     in_x_pos,
  input  logic [7:0]     in_y_pos,
  input  logic [1:0]     in_scale,
  output logic           push_valid,
  input  logic           push_ready,
  output gpr_pkg::desc_t push_desc
);
  import gpr_pkg::*;

  localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

  logic                   scale2;
  logic [GLYPH_IDX_W-1:0] glyph_idx;

  // clamp out-of-range codes to glyph zero
  assign glyph_idx = ({1'b0, in_glyph_code} < GLYPH_LIMIT) ?
                     in_glyph_code[GLYPH_IDX_W-1:0] : '0;
  assign scale2    = (in_scale == SCALE_TWO);

  // build the descriptor
  always_comb begin
    push_desc.bits    = font_glyph(glyph_idx);
    push_desc.x_first = in_x_pos;
    push_desc.x_last  = in_x_pos + (scale2 ? X_SPAN_TWO : X_SPAN_ONE);
    push_desc.y_first = in_y_pos;
    push_desc.y_last  = in_y_pos + (scale2 ? Y_SPAN_TWO : Y_SPAN_ONE);
    push_desc.scale2  = scale2;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

@@ rtl/core/gpr_queue.sv @@
module gpr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gpr_pkg::desc_t push_desc,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gpr_pkg::desc_t pop_desc
);
  import gpr_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_desc   = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ rtl/core/gpr_back.sv @@
module gpr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  gpr_pkg::desc_t        pop_desc,
  input  logic [7:0]            set_colour,
  input  logic [7:0]            clear_colour,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_win_x_first,
  output logic [7:0]            out_win_x_last,
  output logic [7:0]            out_win_y_first,
  output logic [7:0]            out_win_y_last,
  output logic [7:0]            out_pixel_byte,
  output logic                  out_last_pixel,
  output gpr_pkg::back_status_t status
);
  import gpr_pkg::*;

  desc_t      cur_r;
  logic       busy_r, busy_nxt;
  logic [2:0] row_r, row_nxt;
  logic       rep_r, rep_nxt;
  logic [1:0] col_r, col_nxt;
  logic       dup_r, dup_nxt;
  logic       out_valid_r;
  logic [7:0] x_first_r, x_last_r, y_first_r, y_last_r, pixel_r;
  logic       last_r;
  logic       step, load, is_last, pix_bit;
  logic [3:0] bit_idx;

  assign pop_ready = !busy_r;
  assign load      = pop_valid && pop_ready;
  assign step      = busy_r && (!out_valid_r || out_ready);

  // current pixel
  assign bit_idx = 4'(row_r) * 4'd3 + 4'(col_r);
  assign pix_bit = cur_r.bits[LAST_BIT - bit_idx];
  assign is_last = (row_r == LAST_ROW) && (col_r == LAST_COL) &&
                   (!cur_r.scale2 || (rep_r && dup_r));

  // row, repeat, column, duplicate sequencer
  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    rep_nxt  = rep_r;
    col_nxt  = col_r;
    dup_nxt  = dup_r;
    if (load) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      rep_nxt  = 1'b0;
      col_nxt  = '0;
      dup_nxt  = 1'b0;
    end else if (step) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end
      if (cur_r.scale2 && !dup_r) begin
        dup_nxt = 1'b1;
      end else begin
        dup_nxt = 1'b0;
        if (col_r != LAST_COL) begin
          col_nxt = col_r + 2'd1;
        end else begin
          col_nxt = '0;
          if (cur_r.scale2 && !rep_r) begin
            rep_nxt = 1'b1;
          end else begin
            rep_nxt = 1'b0;
            row_nxt = row_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      rep_r       <= 1'b0;
      col_r       <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      rep_r  <= rep_nxt;
      col_r  <= col_nxt;
      dup_r  <= dup_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // descriptor and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= pop_desc;
    end
    if (step) begin
      x_first_r <= cur_r.x_first;
      x_last_r  <= cur_r.x_last;
      y_first_r <= cur_r.y_first;
      y_last_r  <= cur_r.y_last;
      pixel_r   <= pix_bit ? set_colour : clear_colour;
      last_r    <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_win_x_first   = x_first_r;
  assign out_win_x_last    = x_last_r;
  assign out_win_y_first   = y_first_r;
  assign out_win_y_last    = y_last_r;
  assign out_pixel_byte    = pixel_r;
  assign out_last_pixel    = last_r;
  assign status.active     = busy_r;
  assign status.final_step = step && is_last;

endmodule

@@ rtl/core/glyph_pixel_renderer_3x5_top.sv @@
// channel  | direction | handshake              | payload
// in       | input     | in_valid / in_ready    | glyph_code, x_pos, y_pos, scale
// out      | output    | out_valid / out_ready  | window corners, pixel_byte, last_pixel
// cfg      | input     | cfg_wr_en              | cfg_index, cfg_data
//
// one pixel per cycle from the back-end sequencer while out_ready is high: 15 pixels
// at scale 1, 60 at scale 2; the next request leaves the queue only after a glyph ends.
// a two-entry queue lets the front take requests while a glyph is drawn.
// synchronous active-low reset clears queue, sequencer and output valid;
// colours reset to 255 (set), 0 (clear); a pending pixel with out_ready low freezes the sequencer.
`include "glyph_pixel_renderer_3x5_top_macros.svh"

module glyph_pixel_renderer_3x5_top #(
  parameter int GLYPH_COUNT = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_glyph_code,
  input  logic [7:0] in_x_pos,
  input  logic [7:0] in_y_pos,
  input  logic [1:0] in_scale,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_win_x_first,
  output logic [7:0] out_win_x_last,
  output logic [7:0] out_win_y_first,
  output logic [7:0] out_win_y_last,
  output logic [7:0] out_pixel_byte,
  output logic       out_last_pixel,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import gpr_pkg::*;

  logic         push_valid, push_ready;
  logic         pop_valid, pop_ready;
  desc_t        push_desc, pop_desc;
  back_status_t back_status;
  logic [7:0]   set_colour_r, clear_colour_r;
  logic         win_x_two, win_y_two, out_final, all_idle;

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_colour_r   <= 8'hFF;
      clear_colour_r <= 8'h00;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SET_COLOUR:   set_colour_r   <= cfg_data;
        REG_CLEAR_COLOUR: clear_colour_r <= cfg_data;
        default:          set_colour_r   <= set_colour_r;
      endcase
    end
  end

  // request intake
  gpr_front #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_glyph_code (in_glyph_code),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_scale      (in_scale),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_desc     (push_desc)
  );

  // decoupling queue
  gpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  // pixel sequencer
  gpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_desc        (pop_desc),
    .set_colour      (set_colour_r),
    .clear_colour    (clear_colour_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_win_x_first (out_win_x_first),
    .out_win_x_last  (out_win_x_last),
    .out_win_y_first (out_win_y_first),
    .out_win_y_last  (out_win_y_last),
    .out_pixel_byte  (out_pixel_byte),
    .out_last_pixel  (out_last_pixel),
    .status          (back_status)
  );

  // check terms
  assign win_x_two = (out_win_x_last == out_win_x_first + X_SPAN_TWO);
  assign win_y_two = (out_win_y_last == out_win_y_first + Y_SPAN_TWO);
  assign out_final = out_valid && out_last_pixel;
  assign all_idle  = !pop_valid && !back_status.active && !out_valid;

  // checks
  `GPR_ASSERT_NEXT(a_push_lands, in_valid && in_ready, pop_valid, "accepted request not queued")
  `GPR_ASSERT_NEXT(a_final_flag, back_status.final_step, out_final, "final pixel not flagged")
  `GPR_ASSERT_SAME(a_window_scale, out_valid, win_x_two == win_y_two, "window extents disagree")
  `GPR_ASSERT_NEXT(a_idle_quiet, all_idle, !out_valid, "pixel emitted with no request")

endmodule
